// ===== sv/hsit_pkg.sv =====
// Package for the HID short item tokenizer: constants, types and tag lookup.
package hsit_pkg;

	localparam int MAX_DEPTH = 15;
	localparam logic [3:0] DEPTH_LIMIT = (MAX_DEPTH > 15) ? 4'd15 : 4'(MAX_DEPTH);

	localparam logic [7:0] TAG_COLLECTION     = 8'hA1;
	localparam logic [7:0] TAG_END_COLLECTION = 8'hC0;
	localparam logic [1:0] SIZE_CODE_FOUR     = 2'd3;

	localparam int IN_DATA_W  = 8;
	localparam int OUT_DATA_W = 56;

	typedef struct packed {
		logic [7:0]  held_prefix;
		logic [31:0] value_accum;
		logic [2:0]  bytes_left;
		logic [1:0]  bytes_seen;
		logic [3:0]  nesting;
		logic        halted;
	} parse_state_t;

	typedef struct packed {
		logic [7:0]  item_prefix;
		logic [31:0] item_value;
		logic [2:0]  value_size;
		logic [3:0]  nest_level;
		logic        top_closed;
		logic        bad_prefix;
		logic        cut_short;
	} result_t;

	localparam parse_state_t STATE_RESET = '{
		held_prefix: 8'd0, value_accum: 32'd0, bytes_left: 3'd0,
		bytes_seen: 2'd0, nesting: 4'd0, halted: 1'b0
	};

	function automatic logic [2:0] announced_size(input logic [7:0] prefix);
		return (prefix[1:0] == SIZE_CODE_FOUR) ? 3'd4 : {1'b0, prefix[1:0]};
	endfunction

	// Known main, global and local short-item prefixes.
	function automatic logic tag_known(input logic [7:0] prefix);
		logic hit;
		hit = 1'b0;
		unique case (prefix)
			8'h81, 8'h91, 8'hB1, 8'hA1, 8'hC0,
			8'h05, 8'h06, 8'h15, 8'h16, 8'h17, 8'h25, 8'h26, 8'h27,
			8'h35, 8'h36, 8'h37, 8'h45, 8'h46, 8'h47, 8'h55, 8'h65,
			8'h66, 8'h67, 8'h75, 8'h76, 8'h77, 8'h85, 8'h95, 8'h96,
			8'h97, 8'hA4, 8'hB4,
			8'h09, 8'h19, 8'h29: hit = 1'b1;
			default: hit = 1'b0;
		endcase
		return hit;
	endfunction

endpackage

// ===== sv/hid_short_item_tokenizer.sv =====
// HID report descriptor short item tokenizer, top level.
// Flow: a byte is registered in the input stage on accept, and its result item,
// if any, goes to the output register once it is free, raising m_tvalid.
// Throughput: one descriptor byte per cycle, limited only by output backpressure.
// Reset: arst_n clears the parser state and both valid flags asynchronously.
module hid_short_item_tokenizer import hsit_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_tvalid,
	output logic                  s_tready,
	input  logic [IN_DATA_W-1:0]  s_tdata,  // desc_byte[7:0]
	input  logic                  s_tlast,  // final_byte
	output logic                  m_tvalid,
	input  logic                  m_tready,
	// item_prefix[7:0], item_value[39:8], value_size[42:40], nest_level[46:43],
	// top_closed[47], bad_prefix[48], cut_short[49], zero pad[55:50]
	output logic [OUT_DATA_W-1:0] m_tdata
);

	logic         valid_s1;
	logic [7:0]   byte_s1;
	logic         last_s1;
	parse_state_t state_q;
	parse_state_t state_nxt;
	result_t      step_res;
	logic         step_res_valid;
	logic         out_free;
	logic         advance;
	result_t      res_s2;

	hsit_step u_step (
		.cur        (state_q),
		.desc_byte  (byte_s1),
		.final_byte (last_s1),
		.nxt        (state_nxt),
		.res        (step_res),
		.res_valid  (step_res_valid)
	);

	// a byte that yields no result never waits on the output side
	assign advance  = valid_s1 && (out_free || !step_res_valid);
	assign s_tready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			state_q  <= STATE_RESET;
		end else begin
			if (s_tready)
				valid_s1 <= s_tvalid;
			if (advance)
				state_q <= state_nxt;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			byte_s1 <= s_tdata;
			last_s1 <= s_tlast;
		end
	end

	hsit_out_reg u_out (
		.clk      (clk),
		.arst_n   (arst_n),
		.load     (advance && step_res_valid),
		.load_res (step_res),
		.m_tready (m_tready),
		.m_tvalid (m_tvalid),
		.res_s2   (res_s2),
		.free     (out_free)
	);

	assign m_tdata = {6'd0, res_s2.cut_short, res_s2.bad_prefix, res_s2.top_closed,
		res_s2.nest_level, res_s2.value_size, res_s2.item_value, res_s2.item_prefix};

endmodule

// ===== sv/hsit_step.sv =====
// Per-byte parse step: next parser state and the optional result item.
module hsit_step import hsit_pkg::*; (
	input  parse_state_t cur,
	input  logic [7:0]   desc_byte,
	input  logic         final_byte,
	output parse_state_t nxt,
	output result_t      res,
	output logic         res_valid
);

	logic [2:0]  size_b;
	logic [3:0]  nest_dec;
	logic [31:0] accum_new;
	logic [2:0]  left_dec;

	always_comb begin
		size_b    = announced_size(desc_byte);
		nest_dec  = (desc_byte == TAG_END_COLLECTION && cur.nesting != 4'd0) ?
			cur.nesting - 4'd1 : cur.nesting;
		left_dec  = cur.bytes_left - 3'd1;
		accum_new = cur.value_accum;
		unique case (cur.bytes_seen)
			2'd0: accum_new[7:0]   = accum_new[7:0]   | desc_byte;
			2'd1: accum_new[15:8]  = accum_new[15:8]  | desc_byte;
			2'd2: accum_new[23:16] = accum_new[23:16] | desc_byte;
			default: accum_new[31:24] = accum_new[31:24] | desc_byte;
		endcase

		nxt       = cur;
		res_valid = 1'b0;
		res       = '{
			item_prefix: cur.held_prefix, item_value: 32'd0,
			value_size: announced_size(cur.held_prefix), nest_level: cur.nesting,
			top_closed: 1'b0, bad_prefix: 1'b0, cut_short: 1'b0
		};

		if (cur.halted) begin
			// skip bytes until the descriptor ends
		end else if (cur.bytes_left == 3'd0) begin
			res.item_prefix = desc_byte;
			res.value_size  = size_b;
			if (!tag_known(desc_byte)) begin
				res.bad_prefix = 1'b1;
				res_valid      = 1'b1;
				nxt.halted     = 1'b1;
			end else begin
				nxt.held_prefix = desc_byte;
				nxt.value_accum = 32'd0;
				nxt.bytes_seen  = 2'd0;
				nxt.nesting     = nest_dec;
				res.nest_level  = nest_dec;
				if (size_b == 3'd0) begin
					res.top_closed = (desc_byte == TAG_END_COLLECTION) && (nest_dec == 4'd0);
					res_valid      = 1'b1;
					if (desc_byte == TAG_COLLECTION && nest_dec < DEPTH_LIMIT)
						nxt.nesting = nest_dec + 4'd1;
				end else begin
					nxt.bytes_left = size_b;
					res.cut_short  = 1'b1;
					res_valid      = final_byte;
				end
			end
		end else begin
			nxt.value_accum = accum_new;
			nxt.bytes_seen  = cur.bytes_seen + 2'd1;
			nxt.bytes_left  = left_dec;
			res.item_value  = accum_new;
			if (left_dec == 3'd0) begin
				res_valid = 1'b1;
				if (cur.held_prefix == TAG_COLLECTION && cur.nesting < DEPTH_LIMIT)
					nxt.nesting = cur.nesting + 4'd1;
			end else begin
				res.cut_short = 1'b1;
				res_valid     = final_byte;
			end
		end

		if (final_byte)
			nxt = STATE_RESET;
	end

endmodule

// ===== sv/hsit_top_unused_guard.sv =====
// Output holding register with stream handshake for result items.
module hsit_out_reg import hsit_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    load,
	input  result_t load_res,
	input  logic    m_tready,
	output logic    m_tvalid,
	output result_t res_s2,
	output logic    free
);

	assign free = !m_tvalid || m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid <= 1'b0;
		end else if (free) begin
			m_tvalid <= load;
		end
	end

	always_ff @(posedge clk) begin
		if (free && load) begin
			res_s2 <= load_res;
		end
	end

endmodule

// ===== verif/tb_top.sv =====
// Self-checking testbench for the HID short item tokenizer stream block.
module tb_top import hsit_pkg::*;;
	timeunit 1ns;
	timeprecision 1ps;

	localparam logic [7:0] HID_TAGS [35] = '{
		8'h81, 8'h91, 8'hB1, 8'hA1, 8'hC0,
		8'h05, 8'h06, 8'h15, 8'h16, 8'h17, 8'h25, 8'h26, 8'h27,
		8'h35, 8'h36, 8'h37, 8'h45, 8'h46, 8'h47, 8'h55, 8'h65,
		8'h66, 8'h67, 8'h75, 8'h76, 8'h77, 8'h85, 8'h95, 8'h96,
		8'h97, 8'hA4, 8'hB4,
		8'h09, 8'h19, 8'h29
	};

	function automatic bit known_prefix(logic [7:0] p);
		foreach (HID_TAGS[i])
			if (HID_TAGS[i] == p)
				return 1'b1;
		return 1'b0;
	endfunction

	function automatic logic [2:0] data_len(logic [7:0] p);
		case (p[1:0])
			2'd0: return 3'd0;
			2'd1: return 3'd1;
			2'd2: return 3'd2;
			default: return 3'd4;
		endcase
	endfunction

	class hid_item_checker;
		result_t     awaited [$];
		logic [7:0]  held;
		logic [31:0] gathered;
		int          remaining;
		logic [1:0]  seen_cnt;
		logic [3:0]  level;
		bit          stopped;
		int          live_bytes;
		int          mismatches;

		function new();
			restart();
			live_bytes = 0;
			mismatches = 0;
		endfunction

		function void restart();
			held = '0;
			gathered = '0;
			remaining = 0;
			seen_cnt = '0;
			level = '0;
			stopped = 1'b0;
		endfunction

		function void await_item(logic [7:0] p, logic [31:0] v, logic [2:0] sz,
				logic top, logic bad, logic cut);
			result_t r;
			r.item_prefix = p;
			r.item_value = v;
			r.value_size = sz;
			r.nest_level = level;
			r.top_closed = top;
			r.bad_prefix = bad;
			r.cut_short = cut;
			awaited.push_back(r);
		endfunction

		// nesting goes up only once a collection item has all its data
		function void close_item();
			if (held == TAG_COLLECTION && level < DEPTH_LIMIT)
				level++;
		endfunction

		function void take_byte(logic [7:0] b, logic last);
			logic [2:0] sz;
			live_bytes++;
			if (!stopped) begin
				if (remaining == 0) begin
					sz = data_len(b);
					if (!known_prefix(b)) begin
						await_item(b, '0, sz, 1'b0, 1'b1, 1'b0);
						stopped = 1'b1;
					end else begin
						held = b;
						gathered = '0;
						seen_cnt = '0;
						if (b == TAG_END_COLLECTION && level != 0)
							level--;
						if (sz == 0) begin
							await_item(b, '0, sz,
								b == TAG_END_COLLECTION && level == 0,
								1'b0, 1'b0);
							close_item();
						end else begin
							remaining = sz;
							if (last)
								await_item(b, '0, sz, 1'b0, 1'b0, 1'b1);
						end
					end
				end else begin
					gathered |= 32'(b) << (8 * seen_cnt);
					seen_cnt++;
					remaining--;
					if (remaining == 0) begin
						await_item(held, gathered, data_len(held), 1'b0, 1'b0, 1'b0);
						close_item();
					end else if (last) begin
						await_item(held, gathered, data_len(held), 1'b0, 1'b0, 1'b1);
					end
				end
			end
			if (last)
				restart();
		endfunction

		function void check_item(logic [OUT_DATA_W-1:0] d);
			result_t want;
			result_t got;
			bit ok;
			got.item_prefix = d[7:0];
			got.item_value = d[39:8];
			got.value_size = d[42:40];
			got.nest_level = d[46:43];
			got.top_closed = d[47];
			got.bad_prefix = d[48];
			got.cut_short = d[49];
			if (awaited.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected item transaction, data %h", d);
				return;
			end
			want = awaited.pop_front();
			ok = got.item_prefix === want.item_prefix && got.item_value === want.item_value
				&& got.value_size === want.value_size && got.nest_level === want.nest_level
				&& got.top_closed === want.top_closed && got.bad_prefix === want.bad_prefix
				&& got.cut_short === want.cut_short && d[55:50] === 6'd0;
			if (!ok) begin
				mismatches++;
				if (mismatches <= 10) begin
					$display("item mismatch: exp prefix %h value %h size %0d level %0d top %b bad %b cut %b",
						want.item_prefix, want.item_value, want.value_size,
						want.nest_level, want.top_closed, want.bad_prefix, want.cut_short);
					$display("  got prefix %h value %h size %0d level %0d top %b bad %b cut %b pad %h",
						got.item_prefix, got.item_value, got.value_size, got.nest_level,
						got.top_closed, got.bad_prefix, got.cut_short, d[55:50]);
				end
			end
		endfunction
	endclass

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  s_tvalid = 1'b0;
	logic                  s_tready;
	logic [IN_DATA_W-1:0]  s_tdata = '0;   // desc_byte
	logic                  s_tlast = 1'b0;  // final_byte
	logic                  m_tvalid;
	logic                  m_tready = 1'b0;
	// item_prefix, item_value, value_size, nest_level, top_closed, bad_prefix, cut_short
	logic [OUT_DATA_W-1:0] m_tdata;

	hid_item_checker items;
	logic [7:0] desc_q [$];
	int  burst_left = 0;
	bit  calm = 1'b0;
	bit  hold_req = 1'b0;

	hid_short_item_tokenizer u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tlast  (s_tlast),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	initial begin
		#2_000_000;
		$display("tb_top: errors");
		$finish;
	end

	// receiver: changing stall pattern, plus a long hold-off on request
	initial begin
		int mode;
		int span;
		int stall_left;
		mode = 0;
		span = 0;
		stall_left = 0;
		forever begin
			@(posedge clk);
			if (stall_left > 0) begin
				stall_left--;
				m_tready <= 1'b0;
			end else if (hold_req) begin
				hold_req = 1'b0;
				stall_left = 400;
				m_tready <= 1'b0;
			end else begin
				if (span == 0) begin
					mode = $urandom_range(0, 3);
					span = $urandom_range(32, 256);
				end
				span--;
				case (mode)
					0: m_tready <= 1'b1;
					1: m_tready <= 1'($urandom_range(0, 1));
					2: m_tready <= ($urandom_range(0, 7) != 0);
					default: m_tready <= ($urandom_range(0, 7) == 0);
				endcase
			end
		end
	end

	always @(posedge clk)
		if (arst_n && m_tvalid && m_tready)
			items.check_item(m_tdata);

	task automatic send_byte(logic [7:0] b, logic last);
		int gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 24);
			if (!calm) begin
				gap = $urandom_range(1, 6);
				s_tvalid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		burst_left--;
		s_tvalid <= 1'b1;
		s_tdata <= b;
		s_tlast <= last;
		do @(posedge clk); while (!s_tready);
		items.take_byte(b, last);
	endtask

	task automatic send_desc();
		foreach (desc_q[i])
			send_byte(desc_q[i], i == desc_q.size() - 1);
		desc_q.delete();
	endtask

	task automatic drain();
		s_tvalid <= 1'b0;
		burst_left = 0;
		do @(posedge clk); while (items.awaited.size() != 0);
	endtask

	function automatic void add_item(logic [7:0] p);
		int fill;
		fill = $urandom_range(0, 9);
		desc_q.push_back(p);
		repeat (data_len(p))
			desc_q.push_back(fill == 0 ? 8'h00 : fill == 1 ? 8'hFF : 8'($urandom));
	endfunction

	function automatic void add_items(int n);
		int r;
		repeat (n) begin
			r = $urandom_range(0, 99);
			if (r < 15)
				add_item(TAG_COLLECTION);
			else if (r < 30)
				add_item(TAG_END_COLLECTION);
			else
				add_item(HID_TAGS[$urandom_range(0, 34)]);
		end
	endfunction

	// nests up to or past the depth limit, then unwinds below zero
	function automatic void add_deep_nest();
		int depth;
		depth = $urandom_range(14, 20);
		repeat (depth) begin
			add_item(TAG_COLLECTION);
			if ($urandom_range(0, 1))
				add_items(1);
		end
		add_items(3);
		repeat (depth + 1) add_item(TAG_END_COLLECTION);
	endfunction

	function automatic logic [7:0] stray_prefix();
		logic [7:0] p;
		do p = 8'($urandom); while (known_prefix(p));
		return p;
	endfunction

	initial begin
		int iter;
		int k;
		items = new();
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;

		// typical mouse-like descriptor, all sizes, closing below top level
		desc_q = '{8'h05, 8'h01, 8'h09, 8'h02, 8'hA1, 8'h01, 8'h09, 8'h01, 8'hA1, 8'h00,
			8'h19, 8'h01, 8'h29, 8'h03, 8'h15, 8'h00, 8'h25, 8'h01, 8'h06, 8'h00, 8'hFF,
			8'h27, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'h17, 8'h00, 8'h00, 8'h00, 8'h80,
			8'hA4, 8'hB4, 8'h81, 8'h02, 8'hC0, 8'hC0, 8'hC0};
		send_desc();
		// unknown prefix halts; trailing bytes ignored until the final one
		desc_q = '{8'h05, 8'h01, 8'h00, 8'h09, 8'h12};
		send_desc();
		// descriptor ends inside data, right after a prefix, and inside a collection
		desc_q = '{8'h27, 8'h11, 8'h22};
		send_desc();
		desc_q = '{8'h15};
		send_desc();
		desc_q = '{8'hA1};
		send_desc();
		desc_q = '{8'hC0};
		send_desc();
		drain();

		iter = 0;
		while (items.live_bytes < 2000) begin
			calm = ($urandom_range(0, 4) == 0);
			k = $urandom_range(0, 99);
			if (iter == 4) begin
				// receiver holds off while the sender keeps pushing
				hold_req = 1'b1;
				calm = 1'b1;
				add_items(40);
			end else if (k < 55) begin
				add_items($urandom_range(1, 30));
			end else if (k < 67) begin
				add_deep_nest();
			end else if (k < 80) begin
				add_items($urandom_range(1, 10));
				repeat ($urandom_range(0, desc_q.size() - 1)) void'(desc_q.pop_back());
			end else if (k < 92) begin
				add_items($urandom_range(0, 6));
				desc_q.push_back(stray_prefix());
				repeat ($urandom_range(0, 8)) desc_q.push_back(8'($urandom));
			end else begin
				repeat ($urandom_range(1, 16)) desc_q.push_back(8'($urandom));
			end
			send_desc();
			if (iter % 25 == 12)
				drain();
			iter++;
		end

		drain();
		repeat (8) @(posedge clk);
		if (items.mismatches == 0 && items.awaited.size() == 0)
			$display("tb_top: clean");
		else
			$display("tb_top: errors");
		$finish;
	end
endmodule

// ===== hid_short_item_tokenizer.f =====
sv/hsit_pkg.sv
sv/hsit_step.sv
sv/hsit_top_unused_guard.sv
sv/hid_short_item_tokenizer.sv
verif/tb_top.sv
